### design/assert_macros.svh
// Assertion macros used by the allocator design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### design/bffa_pkg.sv
package bffa_pkg;

   localparam int WORD_BITS           = 32;
   localparam int BIT_IDX_W           = 5;
   localparam int BITMAP_BITS_DEFAULT = 8192;
   localparam int NUM_W               = 14;

   localparam logic [NUM_W-1:0] OBJECT_COUNT_RESET = 14'd8192;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_NONE_FREE    = 2'd1,
      STATUS_RANGE        = 2'd2,
      STATUS_ALREADY_FREE = 2'd3
   } status_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } ram_ctl_type;

endpackage

### design/bffa_bitmap_ram.sv
module bffa_bitmap_ram
   import bffa_pkg::*;
#(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic                 clock,
   input  ram_ctl_type          ctl,
   input  logic [AW-1:0]        wr_addr,
   input  logic [WORD_BITS-1:0] wr_data,
   input  logic [AW-1:0]        rd_addr,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/bffa_find_first.sv
module bffa_find_first
   import bffa_pkg::*;
(
   input  logic [WORD_BITS-1:0] vec,
   output logic                 found,
   output logic [BIT_IDX_W-1:0] index
);

   logic [WORD_BITS-1:0] lowest;

   always_comb begin
      lowest = vec & (~vec + WORD_BITS'(1));
      index  = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (lowest[i]) begin
            index = index | BIT_IDX_W'(i);
         end
      end
   end

   assign found = |vec;

endmodule

### design/bitmap_first_free_allocator.sv
// First-fit object allocator over a bitmap of BITMAP_BITS usage bits, kept as 32-bit words in a
// single-port-write, registered-read memory, with a flip-flop summary of full words. An allocate
// transaction scans the summary 32 words per cycle for the first word with a free bit, reads
// that word and takes its lowest clear bit, so its response is registered after the summary scan,
// which steps through up to CHUNKS 32-word summary groups (8 at the default size), the word
// check in ST_ALLOC_CHECK and ST_RESPOND. A free transaction reads and checks one word, writes
// it back when the object was in use, and registers its response through ST_FREE_CHECK and
// ST_RESPOND, or through ST_RESPOND alone when the number is out of range. The block returns to
// idle, ready for the next request, as a response is registered. A finished response is held in
// an output register, so the next request is accepted while it waits; only when a further
// response is ready before the sink has taken the previous one does the block stall. After reset
// and after every write of the object count the bitmap is cleared one word per cycle, all
// BITMAP_BITS / 32 words (256 at the default size), during which no request is accepted.
`include "assert_macros.svh"

module bitmap_first_free_allocator
   import bffa_pkg::*;
#(
   parameter int BITMAP_BITS = BITMAP_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // object_number[13:0], zero[15:14]
   input  logic [0:0]  req_tuser,   // cmd[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // allocated_number[13:0], free_count[27:14], zero[31:28]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   input  logic        csr_wen,
   input  logic [13:0] csr_wdata
);

   localparam int WORDS      = (BITMAP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int CHUNKS     = (WORDS + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CHUNK_W    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int IDX_W      = WORD_AW + BIT_IDX_W;
   localparam int CMP_W      = ((IDX_W > NUM_W) ? IDX_W : NUM_W) + 1;
   localparam int PAD_BITS   = CHUNKS * WORD_BITS;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_ALLOC_CHECK,
      ST_FREE_CHECK,
      ST_RESPOND
   } state_type;

   state_type            state_ff, state_in;
   logic [WORD_AW-1:0]   clear_ff, clear_in;
   logic [CHUNK_W-1:0]   chunk_ff, chunk_in;
   logic [WORD_AW-1:0]   word_ff, word_in;
   logic [BIT_IDX_W-1:0] bit_ff, bit_in;
   logic [NUM_W-1:0]     object_count_ff, object_count_in;
   logic [NUM_W-1:0]     free_ff, free_in;
   logic [WORDS-1:0]     summary_ff, summary_in;
   status_type           res_status_ff, res_status_in;
   logic [NUM_W-1:0]     res_given_ff, res_given_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [NUM_W-1:0]     rsp_given_ff, rsp_given_in;
   logic [NUM_W-1:0]     rsp_free_ff, rsp_free_in;

   ram_ctl_type          ram_ctl;
   logic [WORD_AW-1:0]   ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;
   logic [WORD_AW-1:0]   ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;

   logic [WORD_BITS-1:0] ff_vec;
   logic                 ff_found;
   logic [BIT_IDX_W-1:0] ff_index;

   logic [NUM_W-1:0]     lim;
   logic [NUM_W-1:0]     req_num;
   logic [NUM_W-1:0]     num_m1;
   logic [PAD_BITS-1:0]  summary_pad;
   logic [WORD_BITS-1:0] chunk_sel;
   logic [WORD_AW-1:0]   scan_word;
   logic [IDX_W-1:0]     cand;
   logic [WORD_BITS-1:0] new_word;
   logic                 alloc_ok;

   bffa_bitmap_ram #(
      .DEPTH(WORDS),
      .AW   (WORD_AW)
   ) u_ram (
      .clock  (clock),
      .ctl    (ram_ctl),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   bffa_find_first u_find (
      .vec  (ff_vec),
      .found(ff_found),
      .index(ff_index)
   );

   assign lim     = (32'(object_count_ff) > BITMAP_BITS) ? NUM_W'(BITMAP_BITS) : object_count_ff;
   assign req_num = req_tdata[NUM_W-1:0];
   assign num_m1  = req_num - NUM_W'(1);

   always_comb begin
      summary_pad             = '1;
      summary_pad[WORDS-1:0]  = summary_ff;
   end

   assign chunk_sel = summary_pad[{chunk_ff, BIT_IDX_W'(0)} +: WORD_BITS];
   assign ff_vec    = (state_ff == ST_ALLOC_CHECK) ? ~ram_rd_data : ~chunk_sel;
   assign new_word  = ram_rd_data | (WORD_BITS'(1) << ff_index);
   assign scan_word = WORD_AW'({chunk_ff, ff_index});
   assign cand      = {word_ff, ff_index};
   assign alloc_ok  = CMP_W'(cand) < CMP_W'(lim);

   always_comb begin
      state_in        = state_ff;
      clear_in        = clear_ff;
      chunk_in        = chunk_ff;
      word_in         = word_ff;
      bit_in          = bit_ff;
      object_count_in = object_count_ff;
      free_in         = free_ff;
      summary_in      = summary_ff;
      res_status_in   = res_status_ff;
      res_given_in    = res_given_ff;
      rsp_tvalid_in   = rsp_tvalid_ff & ~rsp_tready;
      rsp_status_in   = rsp_status_ff;
      rsp_given_in    = rsp_given_ff;
      rsp_free_in     = rsp_free_ff;
      ram_ctl         = '0;
      ram_wr_addr     = word_ff;
      ram_wr_data     = '0;
      ram_rd_addr     = word_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_ctl.wr_en = 1'b1;
            ram_wr_addr   = clear_ff;
            free_in       = lim;
            summary_in    = '0;
            if (clear_ff == WORD_AW'(WORDS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clear_in = clear_ff + WORD_AW'(1);
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser[0] == CMD_ALLOC) begin
                  chunk_in = '0;
                  state_in = ST_SCAN;
               end else if (req_num == '0 || req_num > lim) begin
                  res_status_in = STATUS_RANGE;
                  res_given_in  = '0;
                  state_in      = ST_RESPOND;
               end else begin
                  word_in       = WORD_AW'(num_m1 >> BIT_IDX_W);
                  bit_in        = num_m1[BIT_IDX_W-1:0];
                  ram_ctl.rd_en = 1'b1;
                  ram_rd_addr   = WORD_AW'(num_m1 >> BIT_IDX_W);
                  state_in      = ST_FREE_CHECK;
               end
            end
         end
         ST_SCAN: begin
            if (ff_found) begin
               word_in       = scan_word;
               ram_ctl.rd_en = 1'b1;
               ram_rd_addr   = scan_word;
               state_in      = ST_ALLOC_CHECK;
            end else if (chunk_ff == CHUNK_W'(CHUNKS - 1)) begin
               res_status_in = STATUS_NONE_FREE;
               res_given_in  = '0;
               state_in      = ST_RESPOND;
            end else begin
               chunk_in = chunk_ff + CHUNK_W'(1);
            end
         end
         ST_ALLOC_CHECK: begin
            if (alloc_ok) begin
               ram_ctl.wr_en       = 1'b1;
               ram_wr_data         = new_word;
               summary_in[word_ff] = &new_word;
               if (free_ff != '0) begin
                  free_in = free_ff - NUM_W'(1);
               end
               res_status_in = STATUS_OK;
               res_given_in  = NUM_W'(cand) + NUM_W'(1);
            end else begin
               res_status_in = STATUS_NONE_FREE;
               res_given_in  = '0;
            end
            state_in = ST_RESPOND;
         end
         ST_FREE_CHECK: begin
            if (!ram_rd_data[bit_ff]) begin
               res_status_in = STATUS_ALREADY_FREE;
            end else begin
               ram_ctl.wr_en       = 1'b1;
               ram_wr_data         = ram_rd_data & ~(WORD_BITS'(1) << bit_ff);
               summary_in[word_ff] = 1'b0;
               if (free_ff < lim) begin
                  free_in = free_ff + NUM_W'(1);
               end
               res_status_in = STATUS_OK;
            end
            res_given_in = '0;
            state_in     = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_given_in  = res_given_ff;
               rsp_free_in   = free_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clear_in = '0;
         end
      endcase

      if (csr_wen) begin
         object_count_in = csr_wdata;
         clear_in        = '0;
         state_in        = ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clear_ff        <= '0;
         object_count_ff <= OBJECT_COUNT_RESET;
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clear_ff        <= clear_in;
         object_count_ff <= object_count_in;
         rsp_tvalid_ff   <= rsp_tvalid_in;
      end
      chunk_ff      <= chunk_in;
      word_ff       <= word_in;
      bit_ff        <= bit_in;
      free_ff       <= free_in;
      summary_ff    <= summary_in;
      res_status_ff <= res_status_in;
      res_given_ff  <= res_given_in;
      rsp_status_ff <= rsp_status_in;
      rsp_given_ff  <= rsp_given_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {4'd0, rsp_free_ff, rsp_given_ff};

   `ASSERT_IMPLIES(a_free_within_limit, clock, reset, state_ff != ST_CLEAR, free_ff <= lim)
   `ASSERT_IMPLIES(a_number_only_on_ok, clock, reset,
      rsp_tvalid && rsp_status_ff != STATUS_OK, rsp_given_ff == '0)
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready && !csr_wen, !req_tready)
   `ASSERT_NEXT(a_alloc_takes_one, clock, reset,
      state_ff == ST_ALLOC_CHECK && alloc_ok && !csr_wen,
      free_ff == $past(free_ff) - NUM_W'(1))

endmodule

### tb/sv/tb_bitmap_first_free_allocator.sv
module tb_bitmap_first_free_allocator;
   import bffa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int POOL_BITS   = BITMAP_BITS_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 20;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic [0:0]  req_tuser  = CMD_ALLOC;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_wen    = 1'b0;
   logic [13:0] csr_wdata  = '0;

   bit gaps_on = 1'b1;
   int stall_left = 0;

   class alloc_scoreboard;
      typedef struct {
         status_type  status;
         logic [13:0] given;
         logic [13:0] left;
      } outcome_t;

      bit          in_use [POOL_BITS];
      int unsigned usable;
      int unsigned free_left;
      outcome_t    pending [$];
      int          errors = 0;

      function void configure(logic [13:0] count);
         usable = (count > POOL_BITS) ? POOL_BITS : count;
         foreach (in_use[i]) in_use[i] = 1'b0;
         free_left = usable;
      endfunction

      function void note_request(logic cmd, logic [13:0] num);
         outcome_t o;
         int unsigned b;
         o.status = STATUS_OK;
         o.given  = '0;
         if (cmd == CMD_ALLOC) begin
            o.status = STATUS_NONE_FREE;
            for (b = 0; b < usable; b++) begin
               if (!in_use[b]) begin
                  in_use[b] = 1'b1;
                  if (free_left > 0) free_left--;
                  o.given  = 14'(b + 1);
                  o.status = STATUS_OK;
                  break;
               end
            end
         end else if (num == 0 || num > usable) begin
            o.status = STATUS_RANGE;
         end else if (!in_use[num - 1]) begin
            o.status = STATUS_ALREADY_FREE;
         end else begin
            in_use[num - 1] = 1'b0;
            if (free_left < usable) free_left++;
         end
         o.left = 14'(free_left);
         pending.push_back(o);
      endfunction

      function void check_response(logic [1:0] status, logic [13:0] given, logic [13:0] left);
         outcome_t o;
         if (pending.size() == 0) begin
            $display("%0t: response with nothing outstanding: status %0d number %0d free %0d",
                     $time, status, given, left);
            errors++;
            return;
         end
         o = pending.pop_front();
         if (status !== o.status) begin
            $display("%0t: status expected %0d actual %0d", $time, o.status, status);
            errors++;
         end
         if (given !== o.given) begin
            $display("%0t: allocated_number expected %0d actual %0d", $time, o.given, given);
            errors++;
         end
         if (left !== o.left) begin
            $display("%0t: free_count expected %0d actual %0d", $time, o.left, left);
            errors++;
         end
      endfunction
   endclass

   alloc_scoreboard sb = new();

   bitmap_first_free_allocator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb_bitmap_first_free_allocator NOT OK");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tuser, rsp_tdata[13:0], rsp_tdata[27:14]);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 7);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_request(input logic cmd, input logic [13:0] num);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, num};
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, num);
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
   endtask

   // The object count may only change once every outstanding transaction has been answered.
   task automatic set_object_count(input logic [13:0] count);
      end_burst();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= count;
      @(posedge clock);
      sb.configure(count);
      csr_wen <= 1'b0;
   endtask

   initial begin
      logic [13:0] count;
      logic [13:0] num;
      int          issued;
      int          hi;
      int          sel;

      sb.configure(OBJECT_COUNT_RESET);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      repeat (3) send_request(CMD_ALLOC, 14'd0);
      send_request(CMD_FREE, 14'd2);
      send_request(CMD_FREE, 14'd2);
      send_request(CMD_ALLOC, 14'h3FFF);
      send_request(CMD_FREE, 14'd0);
      send_request(CMD_FREE, 14'd8192);
      send_request(CMD_FREE, 14'd8193);
      send_request(CMD_FREE, 14'h3FFF);

      set_object_count(14'd3);
      repeat (4) send_request(CMD_ALLOC, 14'd0);
      send_request(CMD_FREE, 14'd3);
      send_request(CMD_FREE, 14'd4);
      send_request(CMD_ALLOC, 14'd0);

      set_object_count(14'd0);
      send_request(CMD_ALLOC, 14'd0);
      send_request(CMD_FREE, 14'd1);

      set_object_count(14'h3FFF);
      send_request(CMD_ALLOC, 14'd0);
      send_request(CMD_FREE, 14'd8192);

      set_object_count(14'd1);
      send_request(CMD_ALLOC, 14'd0);
      send_request(CMD_ALLOC, 14'd0);
      send_request(CMD_FREE, 14'd1);

      for (int p = 0; p < 10; p++) begin
         case (p)
            0: count = 14'd2;
            1: count = 14'd7;
            2: count = 14'd32;
            3: count = 14'd33;
            4: count = 14'd64;
            5: count = 14'd8192;
            6: count = 14'd8193;
            7: count = 14'($urandom);
            8: count = 14'($urandom_range(1, 200));
            default: count = 14'd100;
         endcase
         set_object_count(count);
         if (p >= 8) gaps_on = 1'b0;
         issued = 0;
         for (int k = 0; k < 40; k++) begin
            if ($urandom_range(0, 99) < 55) begin
               send_request(CMD_ALLOC, 14'($urandom));
               issued++;
            end else begin
               sel = $urandom_range(0, 9);
               hi  = (sb.usable < issued + 2) ? sb.usable : issued + 2;
               if (hi < 1) hi = 1;
               if (sel < 8)
                  num = 14'($urandom_range(1, hi));
               else if (sel == 8)
                  num = 14'($urandom);
               else
                  num = 14'(sb.usable + $urandom_range(0, 1));
               send_request(CMD_FREE, num);
            end
         end
      end

      end_burst();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.errors == 0)
         $display("tb_bitmap_first_free_allocator OK");
      else
         $display("tb_bitmap_first_free_allocator NOT OK");
      $finish;
   end

endmodule
